### hdl/vrrb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrrb_pkg: shared definitions for the variable record ring buffer
// Mode and status codes, the result item layout, and parameter defaults.
// ----------------------------------------------------------------------------
package vrrb_pkg;

  // Parameter defaults for the top level.
  localparam int BUFFER_BYTES_DEF = 4096;
  localparam int HEADER_BYTES_DEF = 8;

  // Ring size register.
  localparam int             CFG_W          = 13;
  localparam logic [CFG_W-1:0] CFG_RESET    = 13'd4096;
  localparam int             MIN_RING_BYTES = 16;

  // Record counter, saturating.
  localparam int             CNT_W   = 13;
  localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

  // Item modes.
  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       record_first;
    logic       record_last;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

### hdl/vrrb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrrb_ram: byte-wide ring storage
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module vrrb_ram #(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hdl/vrrb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrrb_ctrl: record sequencer for the variable record ring buffer
// Holds the ring pointers and counters, walks the storage through reads and
// writes for each item, and clears the storage after reset.
// ----------------------------------------------------------------------------
module vrrb_ctrl #(
  parameter int BUFFER_BYTES = 4096,
  parameter int HEADER_BYTES = 8,
  localparam int PW = $clog2(BUFFER_BYTES + 1),
  localparam int AW = $clog2(BUFFER_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    mode,
  input  wire logic [15:0]   length,
  input  wire logic [7:0]    data_byte,
  input  wire logic [PW-1:0] ring_len,
  output logic               busy,
  output logic               done,
  output vrrb_pkg::res_t     res,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [7:0]         mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire logic [7:0]    mem_rdata
);
  import vrrb_pkg::*;

  localparam int SW = ((PW > 16) ? PW : 16) + 1;
  localparam logic [SW-1:0] HDR_S    = SW'(HEADER_BYTES);
  localparam logic [SW-1:0] BUF_S    = SW'(BUFFER_BYTES);
  localparam logic [AW-1:0] HDR_LAST = AW'(HEADER_BYTES - 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(BUFFER_BYTES - 1);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_ZERO   = 11'b000_0000_0100,
    S_WRAP   = 11'b000_0000_1000,
    S_HDR_LO = 11'b000_0001_0000,
    S_HDR_HI = 11'b000_0010_0000,
    S_SZ_LO  = 11'b000_0100_0000,
    S_SZ_HI  = 11'b000_1000_0000,
    S_SZ_CHK = 11'b001_0000_0000,
    S_POP    = 11'b010_0000_0000,
    S_POP_W  = 11'b100_0000_0000
  } state_t;

  state_t           state;
  logic [AW-1:0]    cnt;
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CNT_W-1:0] count;
  logic [PW-1:0]    wbl;
  logic [PW-1:0]    rbl;
  logic [PW-1:0]    wsize;
  logic [15:0]      len_q;
  logic             dropped;
  logic             hopped;
  logic             first_q;
  logic [7:0]       size_lo;
  logic             rd_oob;

  logic [SW-1:0] wp_s, rp_s, sz_s, len_s, lenq_s, size_s;
  logic [PW-1:0] off;
  logic [7:0]    rd_byte;
  logic [15:0]   size_v;
  logic          begin_bad, ovr1, pending, wrap1, zero_fit;
  logic          we_full;
  logic [SW-1:0] waddr_s, raddr_s;

  // Widened views and the decisions taken at accept time.
  always_comb begin
    wp_s      = SW'(wp);
    rp_s      = SW'(rp);
    sz_s      = SW'(ring_len);
    len_s     = SW'(length);
    lenq_s    = SW'(len_q);
    off       = wsize - wbl;
    rd_byte   = rd_oob ? 8'd0 : mem_rdata;
    size_v    = {rd_byte, size_lo};
    size_s    = SW'(size_v);
    begin_bad = (len_s < HDR_S) || (len_s > sz_s) || (wbl != '0);
    ovr1      = (wp_s <= rp_s) && (wp_s + len_s > rp_s);
    pending   = (count != '0) || (rbl != '0);
    wrap1     = (wp_s + len_s > sz_s);
    zero_fit  = (wp_s + HDR_S <= sz_s);
  end

  // Storage write port.
  always_comb begin
    we_full   = 1'b0;
    waddr_s   = wp_s;
    mem_wdata = 8'd0;
    unique case (state)
      S_CLEAR: begin
        we_full = 1'b1;
        waddr_s = SW'(cnt);
      end
      S_IDLE: begin
        we_full   = start && (mode == MODE_BYTE) && (wbl != '0) && (off >= PW'(2));
        waddr_s   = wp_s + SW'(off);
        mem_wdata = data_byte;
      end
      S_ZERO: begin
        we_full = 1'b1;
        waddr_s = wp_s + SW'(cnt);
      end
      S_HDR_LO: begin
        we_full   = 1'b1;
        mem_wdata = len_q[7:0];
      end
      S_HDR_HI: begin
        we_full   = 1'b1;
        waddr_s   = wp_s + SW'(1);
        mem_wdata = len_q[15:8];
      end
      default: begin
        we_full = 1'b0;
      end
    endcase
    mem_we    = we_full && (waddr_s < BUF_S);
    mem_waddr = waddr_s[AW-1:0];
  end

  // Storage read port: the high size byte in S_SZ_HI, else the read point.
  always_comb begin
    raddr_s   = (state == S_SZ_HI) ? (rp_s + SW'(1)) : rp_s;
    mem_raddr = raddr_s[AW-1:0];
  end

  assign busy = (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    rd_oob <= (raddr_s >= BUF_S);
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      wp    <= '0;
      rp    <= '0;
      count <= '0;
      wbl   <= '0;
      rbl   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + AW'(1);
          if (cnt == CLR_LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            unique case (mode)
              MODE_BEGIN: begin
                if (begin_bad) begin
                  done <= 1'b1;
                  res  <= '{8'd0, 1'b0, 1'b0, 1'b0, ST_REJECT};
                end else begin
                  len_q   <= length;
                  dropped <= ovr1 && pending;
                  if (ovr1) begin
                    rp    <= wp;
                    count <= '0;
                    rbl   <= '0;
                  end
                  if (wrap1 && zero_fit) begin
                    cnt   <= '0;
                    state <= S_ZERO;
                  end else if (wrap1) begin
                    state <= S_WRAP;
                  end else begin
                    state <= S_HDR_LO;
                  end
                end
              end
              MODE_BYTE: begin
                if (wbl != '0) begin
                  wbl <= wbl - PW'(1);
                  if (wbl == PW'(1)) begin
                    wp <= wp + wsize;
                    if (count != CNT_MAX) begin
                      count <= count + CNT_W'(1);
                    end
                  end
                end
                done <= 1'b1;
                res  <= '{8'd0, 1'b0, 1'b0, 1'b0, ST_OK};
              end
              MODE_READ: begin
                len_q   <= length;
                first_q <= 1'b0;
                if (rbl != '0) begin
                  // The byte at the read point is being fetched already.
                  state <= S_POP_W;
                end else if (count == '0) begin
                  done <= 1'b1;
                  res  <= '{8'd0, 1'b0, 1'b0, 1'b0, ST_EMPTY};
                end else begin
                  hopped <= 1'b0;
                  if (rp_s + HDR_S > sz_s) begin
                    rp     <= '0;
                    hopped <= 1'b1;
                  end
                  state <= S_SZ_LO;
                end
              end
              default: begin
                wp    <= '0;
                rp    <= '0;
                count <= '0;
                wbl   <= '0;
                rbl   <= '0;
                done  <= 1'b1;
                res   <= '{8'd0, 1'b0, 1'b0, 1'b0, ST_OK};
              end
            endcase
          end
        end
        // Zero the header at the old write point as a wrap marker.
        S_ZERO: begin
          cnt <= cnt + AW'(1);
          if (cnt == HDR_LAST) begin
            state <= S_WRAP;
          end
        end
        // Restart at offset zero and repeat the overrun test there.
        S_WRAP: begin
          wp <= '0;
          if (lenq_s > rp_s) begin
            if (pending) begin
              dropped <= 1'b1;
            end
            rp    <= '0;
            count <= '0;
            rbl   <= '0;
          end
          state <= S_HDR_LO;
        end
        S_HDR_LO: begin
          state <= S_HDR_HI;
        end
        S_HDR_HI: begin
          wbl   <= PW'(len_q);
          wsize <= PW'(len_q);
          done  <= 1'b1;
          res   <= '{8'd0, 1'b0, 1'b0, 1'b0, dropped ? ST_DROPPED : ST_OK};
          state <= S_IDLE;
        end
        S_SZ_LO: begin
          state <= S_SZ_HI;
        end
        S_SZ_HI: begin
          size_lo <= rd_byte;
          state   <= S_SZ_CHK;
        end
        // Check the size field of the record at the read point.
        S_SZ_CHK: begin
          if (!hopped && (size_v == 16'd0)) begin
            rp     <= '0;
            hopped <= 1'b1;
            state  <= S_SZ_LO;
          end else if ((size_s < HDR_S) || (rp_s + size_s > sz_s)) begin
            count <= '0;
            rbl   <= '0;
            rp    <= wp;
            done  <= 1'b1;
            res   <= '{8'd0, 1'b0, 1'b0, 1'b0, ST_EMPTY};
            state <= S_IDLE;
          end else if (size_v > len_q) begin
            done  <= 1'b1;
            res   <= '{8'd0, 1'b0, 1'b0, 1'b0, ST_EMPTY};
            state <= S_IDLE;
          end else begin
            rbl     <= PW'(size_v);
            first_q <= 1'b1;
            state   <= S_POP;
          end
        end
        S_POP: begin
          state <= S_POP_W;
        end
        // Deliver the fetched byte and advance the read point.
        S_POP_W: begin
          rp   <= rp + PW'(1);
          rbl  <= rbl - PW'(1);
          if ((rbl == PW'(1)) && (count != '0)) begin
            count <= count - CNT_W'(1);
          end
          done  <= 1'b1;
          res   <= '{rd_byte, 1'b1, first_q, (rbl == PW'(1)), ST_OK};
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/variable_record_ring_buffer.sv
`default_nettype none
// Byte writes, clears and rejected items give their result in the cycle after start; a
// record begin writes its header in S_HDR_LO and S_HDR_HI, after S_WRAP on a wrap and S_ZERO
// before it when a marker is zeroed. A read inside a record passes S_POP_W; opening a record
// adds S_SZ_LO, S_SZ_HI, S_SZ_CHK and S_POP first, the size states twice past a marker.
// One item at a time; the storage has one write and one registered read port. Reset clears
// it all, busy high. Results are strobed on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// variable_record_ring_buffer: byte ring of variable-length records
// Holds the ring size register and its clamp, the storage and the sequencer.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer #(
  parameter int BUFFER_BYTES = vrrb_pkg::BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES = vrrb_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  output logic                            done,
  input  wire logic                       cfg_write,
  input  wire logic [vrrb_pkg::CFG_W-1:0] cfg_data,
  input  wire logic [1:0]                 mode,
  input  wire logic [15:0]                length,
  input  wire logic [7:0]                 data_byte,
  output logic      [7:0]                 out_byte,
  output logic                            out_valid,
  output logic                            record_first,
  output logic                            record_last,
  output logic      [1:0]                 status
);
  import vrrb_pkg::*;

  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int TW = ((PW > CFG_W) ? PW : CFG_W) + 1;

  logic [CFG_W-1:0] buffer_size;
  logic [TW-1:0]    s0, s1, s2;
  logic [PW-1:0]    ring_len;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  // Ring size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= CFG_RESET;
    end else if (cfg_write) begin
      buffer_size <= cfg_data;
    end
  end

  // Bytes of the ring in use, held within the supported range.
  always_comb begin
    s0       = TW'(buffer_size);
    s1       = (s0 < TW'(MIN_RING_BYTES)) ? TW'(MIN_RING_BYTES) : s0;
    s1       = (s1 < TW'(HEADER_BYTES)) ? TW'(HEADER_BYTES) : s1;
    s2       = (s1 > TW'(BUFFER_BYTES)) ? TW'(BUFFER_BYTES) : s1;
    ring_len = PW'(s2);
  end

  vrrb_ram #(
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  vrrb_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .length    (length),
    .data_byte (data_byte),
    .ring_len  (ring_len),
    .busy      (busy),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Result item fields.
  assign out_byte     = res.out_byte;
  assign out_valid    = res.out_valid;
  assign record_first = res.record_first;
  assign record_last  = res.record_last;
  assign status       = res.status;

endmodule
`default_nettype wire

### dv/variable_record_ring_buffer_test.sv
// ----------------------------------------------------------------------------
// variable_record_ring_buffer_test: testbench for the variable record ring
// The driver feeds begin, byte, read and clear items from a queue and keeps
// its own copy of the ring to work out each result. The monitor compares
// every strobed result with the oldest prediction. Directed items come first,
// then random record traffic over several ring sizes.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vrrb_pkg::*;

  localparam int HDR = HEADER_BYTES_DEF;
  localparam int BUF = BUFFER_BYTES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 120;

  // One planned item or one write of the ring size register.
  typedef struct {
    bit          is_cfg;
    logic [12:0] cfg_val;
    logic [1:0]  md;
    logic [15:0] len;
    logic [7:0]  dat;
    int unsigned gap;
  } ring_op_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic             done;
  logic             cfg_write = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic [1:0]       mode = MODE_CLEAR;
  logic [15:0]      length = '0;
  logic [7:0]       data_byte = '0;
  logic [7:0]       out_byte;
  logic             out_valid;
  logic             record_first;
  logic             record_last;
  logic [1:0]       status;

  ring_op_t    pending_ops[$];
  res_t        expected_replies[$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned planned_items = 0;
  int unsigned plan_size;
  bit          quiet = 1'b0;
  bit          final_part = 1'b0;

  // Shadow copy of the ring and its pointers.
  logic [7:0]       ring_mem [0:BUF-1];
  logic [12:0]      wr_pt, rd_pt, rec_cnt, wr_left, rd_left;
  logic [CFG_W-1:0] ring_cfg;

  variable_record_ring_buffer dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .length       (length),
    .data_byte    (data_byte),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .record_first (record_first),
    .record_last  (record_last),
    .status       (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ring bytes in use after the register value is clamped.
  function automatic int unsigned clamp_ring(logic [CFG_W-1:0] v);
    int unsigned s;
    s = v;
    if (s < MIN_RING_BYTES) s = MIN_RING_BYTES;
    if (s < HDR) s = HDR;
    if (s > BUF) s = BUF;
    return s;
  endfunction

  function automatic logic [7:0] store_rd(int unsigned i);
    return (i < BUF) ? ring_mem[i] : 8'h00;
  endfunction

  function automatic void store_wr(int unsigned i, logic [7:0] v);
    if (i < BUF) ring_mem[i] = v;
  endfunction

  function automatic int unsigned size_field(int unsigned i);
    return {store_rd(i + 1), store_rd(i)};
  endfunction

  // A new record that would cover the read point drops everything unread.
  function automatic bit drop_overlap(int unsigned len);
    bit pending;
    if (wr_pt <= rd_pt && wr_pt + len > rd_pt) begin
      pending = (rec_cnt > 0) || (rd_left > 0);
      rd_pt = wr_pt;
      rec_cnt = '0;
      rd_left = '0;
      return pending;
    end
    return 1'b0;
  endfunction

  // Works out the result of one accepted item and advances the shadow ring.
  function automatic res_t predict_ring_step(logic [1:0] md, logic [15:0] len_in,
                                             logic [7:0] dat);
    res_t        r;
    int unsigned sz, len, size, off;
    bit          dropped, hopped, go;
    r = '0;
    sz = clamp_ring(ring_cfg);
    len = len_in;
    case (md)
      MODE_BEGIN: begin
        if (len < HDR || len > sz || wr_left > 0) begin
          r.status = ST_REJECT;
        end else begin
          dropped = drop_overlap(len);
          // A record running past the end leaves a zeroed marker and restarts at zero.
          if (wr_pt + len > sz) begin
            if (wr_pt + HDR <= sz) begin
              for (int k = 0; k < HDR; k++) store_wr(wr_pt + k, 8'h00);
            end
            wr_pt = '0;
            if (drop_overlap(len)) dropped = 1'b1;
          end
          store_wr(wr_pt, len_in[7:0]);
          store_wr(wr_pt + 1, len_in[15:8]);
          wr_left = 13'(len);
          r.status = dropped ? ST_DROPPED : ST_OK;
        end
      end
      MODE_BYTE: begin
        if (wr_left > 0) begin
          size = size_field(wr_pt);
          off = (size >= wr_left) ? size - wr_left : 0;
          // The two size bytes come from the begin item, not from the data.
          if (off >= 2) store_wr(wr_pt + off, dat);
          wr_left = wr_left - 1'b1;
          if (wr_left == 0) begin
            wr_pt = 13'(wr_pt + size);
            if (rec_cnt < CNT_MAX) rec_cnt = rec_cnt + 1'b1;
          end
        end
      end
      MODE_READ: begin
        go = 1'b1;
        if (rd_left == 0) begin
          go = 1'b0;
          if (rec_cnt == 0) begin
            r.status = ST_EMPTY;
          end else begin
            hopped = 1'b0;
            if (rd_pt + HDR > sz || size_field(rd_pt) == 0) begin
              rd_pt = '0;
              hopped = 1'b1;
            end
            size = size_field(rd_pt);
            // A header that cannot be valid throws away everything pending.
            if (size < HDR || rd_pt + size > sz || (hopped && size == 0)) begin
              rec_cnt = '0;
              rd_left = '0;
              rd_pt = wr_pt;
              r.status = ST_EMPTY;
            end else if (size > len) begin
              r.status = ST_EMPTY;
            end else begin
              rd_left = 13'(size);
              r.record_first = 1'b1;
              go = 1'b1;
            end
          end
        end
        if (go) begin
          r.out_byte = store_rd(rd_pt);
          r.out_valid = 1'b1;
          rd_pt = rd_pt + 1'b1;
          rd_left = rd_left - 1'b1;
          if (rd_left == 0) begin
            r.record_last = 1'b1;
            if (rec_cnt > 0) rec_cnt = rec_cnt - 1'b1;
          end
        end
      end
      default: begin
        wr_pt = '0;
        rd_pt = '0;
        rec_cnt = '0;
        wr_left = '0;
        rd_left = '0;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Sender idling comes in bursts, except during quiet stretches.
  task automatic add_item(input logic [1:0] md, input logic [15:0] ln, input logic [7:0] db);
    ring_op_t op;
    op.is_cfg = 1'b0;
    op.cfg_val = '0;
    op.md = md;
    op.len = ln;
    op.dat = db;
    op.gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) op.gap = $urandom_range(1, 9);
    pending_ops.push_back(op);
    planned_items++;
  endtask

  task automatic add_cfg(input logic [12:0] v);
    ring_op_t op;
    op.is_cfg = 1'b1;
    op.cfg_val = v;
    op.md = MODE_CLEAR;
    op.len = '0;
    op.dat = '0;
    op.gap = 0;
    pending_ops.push_back(op);
    plan_size = clamp_ring(v);
  endtask

  // Record lengths: mostly short, some up to the ring size or 64 if smaller, a few out of range.
  function automatic int unsigned pick_length(int unsigned sz);
    int unsigned r, top;
    r = $urandom_range(0, 99);
    top = (sz < 64) ? sz : 64;
    if (r < 70) return $urandom_range(HDR, (sz < 24) ? sz : 24);
    if (r < 85) return $urandom_range(HDR, top);
    if (r < 92) return top;
    if (r < 96) return $urandom_range(0, HDR - 1);
    return $urandom_range(sz + 1, 16'hFFFF);
  endfunction

  // One burst of random traffic: a whole record, a run of reads, a record
  // cut short, a clear, or noise.
  task automatic gen_group();
    int unsigned r, ln, n;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      ln = pick_length(plan_size);
      add_item(MODE_BEGIN, 16'(ln), 8'($urandom));
      if (ln >= HDR && ln <= plan_size) begin
        repeat (ln) add_item(MODE_BYTE, 16'($urandom), 8'($urandom));
      end
    end else if (r < 82) begin
      n = $urandom_range(1, 40);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          add_item(MODE_READ, 16'($urandom_range(0, 24)), 8'($urandom));
        end else begin
          add_item(MODE_READ, 16'($urandom), 8'($urandom));
        end
      end
    end else if (r < 90) begin
      ln = $urandom_range(HDR, (plan_size < 24) ? plan_size : 24);
      add_item(MODE_BEGIN, 16'(ln), 8'($urandom));
      repeat ($urandom_range(0, ln - 1)) add_item(MODE_BYTE, 16'($urandom), 8'($urandom));
    end else if (r < 94) begin
      add_item(MODE_CLEAR, 16'($urandom), 8'($urandom));
    end else begin
      repeat (3) add_item(2'($urandom), 16'($urandom), 8'($urandom));
    end
    if (!final_part && $urandom_range(0, 5) == 0) quiet = !quiet;
  endtask

  // Driver: accepts items, predicts their results and loads the next one.
  always @(posedge clk) begin : drive_proc
    logic     next_start;
    logic     next_cfg;
    ring_op_t head;
    if (rst) begin
      start <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      next_start = start;
      next_cfg = 1'b0;
      if (cfg_write) ring_cfg = cfg_data;
      if (start && !busy) begin
        expected_replies.push_back(predict_ring_step(mode, length, data_byte));
        items_sent++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          head = pending_ops[0];
          if (head.is_cfg) begin
            // The ring size changes only with nothing in flight.
            if (items_sent == results_seen && !busy && !cfg_write) begin
              cfg_data <= head.cfg_val;
              next_cfg = 1'b1;
              void'(pending_ops.pop_front());
            end
          end else if (head.gap > 0) begin
            gap_left = head.gap - 1;
            pending_ops[0].gap = 0;
          end else begin
            mode <= head.md;
            length <= head.len;
            data_byte <= head.dat;
            next_start = 1'b1;
            void'(pending_ops.pop_front());
          end
        end
      end
      start <= next_start;
      cfg_write <= next_cfg;
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin : check_proc
    res_t want;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_replies.size() == 0) begin
        failures++;
        $display("%0t: result with no item outstanding, expected none, actual status %0d",
                 $time, status);
      end else begin
        want = expected_replies.pop_front();
        check_field("out_byte", want.out_byte, out_byte);
        check_field("out_valid", want.out_valid, out_valid);
        check_field("record_first", want.record_first, record_first);
        check_field("record_last", want.record_last, record_last);
        check_field("status", want.status, status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stim_proc
    logic [12:0] cv;
    for (int i = 0; i < BUF; i++) ring_mem[i] = 8'h00;
    wr_pt = '0;
    rd_pt = '0;
    rec_cnt = '0;
    wr_left = '0;
    rd_left = '0;
    ring_cfg = CFG_RESET;
    plan_size = clamp_ring(CFG_RESET);

    // Directed items on the smallest ring.
    add_cfg(13'd16);
    add_item(MODE_READ, 16'hFFFF, 8'h00);
    add_item(MODE_BYTE, 16'h0000, 8'hFF);
    add_item(MODE_BEGIN, 16'(HDR - 1), 8'h00);
    add_item(MODE_BEGIN, 16'd17, 8'h00);
    add_item(MODE_BEGIN, 16'hFFFF, 8'hFF);
    add_item(MODE_BEGIN, 16'(HDR), 8'h00);
    add_item(MODE_BYTE, 16'h0000, 8'hAA);
    add_item(MODE_BYTE, 16'h0000, 8'h55);
    add_item(MODE_BYTE, 16'h0000, 8'h00);
    add_item(MODE_BEGIN, 16'd12, 8'h00);
    add_item(MODE_BYTE, 16'hFFFF, 8'hFF);
    add_item(MODE_BYTE, 16'h0000, 8'h01);
    add_item(MODE_BYTE, 16'h0000, 8'h80);
    add_item(MODE_BYTE, 16'h0000, 8'h7F);
    add_item(MODE_BYTE, 16'h0000, 8'hFE);
    add_item(MODE_READ, 16'(HDR - 1), 8'h00);
    add_item(MODE_READ, 16'(HDR), 8'h00);
    repeat (3) add_item(MODE_READ, 16'h0000, 8'h00);
    add_item(MODE_CLEAR, 16'h0000, 8'h00);

    // Random phases over several ring sizes; data may stay pending across them.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: cv = 13'h1FFF;
        1: cv = 13'h0000;
        2: cv = 13'd64;
        3: cv = 13'($urandom_range(16, 200));
        4: cv = 13'd4096;
        5: cv = 13'd40;
        default: cv = 13'($urandom_range(16, 120));
      endcase
      if (p == 6) begin
        final_part = 1'b1;
        quiet = 1'b1;
      end
      add_cfg(cv);
      if (plan_size == BUF) begin
        add_item(MODE_BEGIN, 16'(BUF), 8'h00);
        add_item(MODE_CLEAR, 16'h0000, 8'h00);
      end
      planned_items = 0;
      while (planned_items < PHASE_ITEMS) gen_group();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_ops.size() == 0 && !start && items_sent == results_seen)) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_replies.size() != 0) begin
      failures++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, expected_replies.size());
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
